/* src/mrsc_pkg.sv */
package mrsc_pkg;

    // One control pass as it arrives on the input stream.
    typedef struct packed {
        logic [31:0] now_ms;
        logic        start_press;
        logic        estop_press;
        logic        upper_limit_hit;
        logic        lower_limit_hit;
        logic [11:0] current_level;
    } t_item;

    // Configuration register file.
    typedef struct packed {
        logic [11:0] current_trip_level;
        logic [31:0] max_run_ms;
        logic [15:0] ramp_step_ms;
        logic [15:0] cruise_ms;
        logic [15:0] debounce_ms;
        logic [7:0]  run_duty;
    } t_cfg;

    // One result of a control pass.
    typedef struct packed {
        logic [2:0]        mode;
        logic signed [8:0] speed;
        logic [7:0]        up_duty;
        logic [7:0]        down_duty;
        logic              fault_lamp;
        logic              overload_fault;
        logic              timeout_fault;
    } t_result;

    // Motor mode state, one-hot.
    typedef enum logic [4:0] {
        ST_OFF    = 5'b00001,
        ST_ACCEL  = 5'b00010,
        ST_CRUISE = 5'b00100,
        ST_DECEL  = 5'b01000,
        ST_EMERG  = 5'b10000
    } t_mode;

    // Mode codes as reported on the result stream.
    localparam logic [2:0] MODE_OFF    = 3'd0;
    localparam logic [2:0] MODE_ACCEL  = 3'd1;
    localparam logic [2:0] MODE_CRUISE = 3'd2;
    localparam logic [2:0] MODE_DECEL  = 3'd3;
    localparam logic [2:0] MODE_EMERG  = 3'd4;

    // Configuration register indexes.
    localparam int         CFG_IDX_W          = 3;
    localparam logic [2:0] CFG_TRIP_LEVEL     = 3'd0;
    localparam logic [2:0] CFG_MAX_RUN        = 3'd1;
    localparam logic [2:0] CFG_RAMP_STEP      = 3'd2;
    localparam logic [2:0] CFG_CRUISE         = 3'd3;
    localparam logic [2:0] CFG_DEBOUNCE       = 3'd4;
    localparam logic [2:0] CFG_RUN_DUTY       = 3'd5;

    // Register values after reset.
    localparam logic [11:0] RST_TRIP_LEVEL = 12'd3000;
    localparam logic [31:0] RST_MAX_RUN    = 32'd12000;
    localparam logic [15:0] RST_RAMP_STEP  = 16'd15;
    localparam logic [15:0] RST_CRUISE     = 16'd2000;
    localparam logic [15:0] RST_DEBOUNCE   = 16'd300;
    localparam logic [7:0]  RST_RUN_DUTY   = 8'd200;

    // Blink phase: now mod 600 < 300. Since 600 = 8 * 75, the low three bits pass
    // straight through and the rest is reduced mod 75 with a reciprocal multiply.
    // The reciprocal is floor(2^36 / 75), so the quotient is low by at most one.
    localparam int          BLINK_SHIFT = 36;
    localparam logic [29:0] BLINK_RECIP = 30'd916259689;
    localparam logic [7:0]  BLINK_DIV   = 8'd75;
    localparam logic [7:0]  BLINK_HALF  = 8'd37;

    function automatic logic [2:0] mode_code(t_mode m);
        logic [2:0] code;
        unique case (m)
            ST_OFF:    code = MODE_OFF;
            ST_ACCEL:  code = MODE_ACCEL;
            ST_CRUISE: code = MODE_CRUISE;
            ST_DECEL:  code = MODE_DECEL;
            ST_EMERG:  code = MODE_EMERG;
            default:   code = MODE_OFF;
        endcase
        return code;
    endfunction

endpackage

/* src/mrsc_blink.sv */
module mrsc_blink (
    input  logic        i_clk,
    input  logic        i_load_quot,
    input  logic        i_load_phase,
    input  logic [31:0] i_now_ms,
    output logic        o_blink_on
);
    import mrsc_pkg::*;

    logic [58:0] product;
    logic [28:0] r_coarse;
    logic [2:0]  r_fine;
    logic [22:0] r_quot;
    logic [28:0] rem_full;
    logic [7:0]  rem_raw;
    logic [7:0]  rem;
    logic        blink_on;
    logic        r_blink_on;

    // First stage: quotient estimate of (now / 8) / 75.
    assign product = 59'(i_now_ms[31:3]) * 59'(BLINK_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_load_quot) begin
            r_coarse <= i_now_ms[31:3];
            r_fine   <= i_now_ms[2:0];
            r_quot   <= product[BLINK_SHIFT +: 23];
        end
    end

    // Second stage: remainder below 150, one correction brings it below 75.
    assign rem_full = r_coarse - (29'(r_quot) * 29'(BLINK_DIV));
    assign rem_raw  = rem_full[7:0];
    assign rem      = (rem_raw >= BLINK_DIV) ? (rem_raw - BLINK_DIV) : rem_raw;

    // Lit for the first half of the 600 ms period: 8 * rem + fine < 300.
    assign blink_on = (rem < BLINK_HALF) || ((rem == BLINK_HALF) && !r_fine[2]);

    always_ff @(posedge i_clk) begin
        if (i_load_phase) begin
            r_blink_on <= blink_on;
        end
    end

    assign o_blink_on = r_blink_on;

endmodule

/* src/mrsc_core.sv */
module mrsc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  mrsc_pkg::t_item   i_item,
    input  logic              i_blink_on,
    input  mrsc_pkg::t_cfg    i_cfg,
    output mrsc_pkg::t_result o_result
);
    import mrsc_pkg::*;

    t_mode             r_mode, n_mode;
    logic signed [8:0] r_speed, n_speed;
    logic signed [8:0] r_target, n_target;
    logic              r_next_dir_down, n_next_dir_down;
    logic [31:0]       r_last_ramp_ms, n_last_ramp_ms;
    logic [31:0]       r_run_start_ms, n_run_start_ms;
    logic [31:0]       r_last_start_ms, n_last_start_ms;
    logic [31:0]       r_last_estop_ms, n_last_estop_ms;
    logic              r_overload, n_overload;
    logic              r_timeout, n_timeout;
    logic              r_lamp, n_lamp;

    logic [31:0]       run_age;
    logic [31:0]       ramp_age;
    logic [31:0]       start_age;
    logic [31:0]       estop_age;
    logic              moving;
    logic              limit_stop;
    logic              trip_over;
    logic              run_over;
    logic              estop_ok;
    logic              start_ok;
    logic              step_due;
    logic              cruise_due;
    logic              go_down;
    logic signed [8:0] mag;
    logic signed [8:0] neg_speed;

    // Elapsed times, all modulo 2^32, taken against the stored timestamps.
    assign run_age   = i_item.now_ms - r_run_start_ms;
    assign ramp_age  = i_item.now_ms - r_last_ramp_ms;
    assign start_age = i_item.now_ms - r_last_start_ms;
    assign estop_age = i_item.now_ms - r_last_estop_ms;

    assign moving     = (r_mode == ST_ACCEL) || (r_mode == ST_CRUISE) || (r_mode == ST_DECEL);
    assign limit_stop = moving && (((r_speed > 9'sd0) && i_item.upper_limit_hit) ||
                                   ((r_speed < 9'sd0) && i_item.lower_limit_hit));
    assign trip_over  = i_item.current_level > i_cfg.current_trip_level;
    assign run_over   = run_age > i_cfg.max_run_ms;
    assign estop_ok   = i_item.estop_press && (estop_age > {16'h0000, i_cfg.debounce_ms});
    assign start_ok   = i_item.start_press && (start_age > {16'h0000, i_cfg.debounce_ms});
    assign step_due   = ramp_age >= {16'h0000, i_cfg.ramp_step_ms};
    assign cruise_due = ramp_age >= {16'h0000, i_cfg.cruise_ms};

    // Direction of a new run: turn away from a limit that is already hit.
    assign go_down = r_next_dir_down ? !i_item.lower_limit_hit : i_item.upper_limit_hit;
    assign mag     = $signed({1'b0, i_cfg.run_duty});

    // One control pass, checks in fixed priority order, then the mode action.
    always_comb begin
        n_mode          = r_mode;
        n_speed         = r_speed;
        n_target        = r_target;
        n_next_dir_down = r_next_dir_down;
        n_last_ramp_ms  = r_last_ramp_ms;
        n_run_start_ms  = r_run_start_ms;
        n_last_start_ms = r_last_start_ms;
        n_last_estop_ms = r_last_estop_ms;
        n_overload      = r_overload;
        n_timeout       = r_timeout;
        n_lamp          = r_lamp;

        if (limit_stop) begin
            n_speed  = 9'sd0;
            n_target = 9'sd0;
            n_mode   = ST_OFF;
        end
        if ((n_mode != ST_OFF) && (n_mode != ST_EMERG) && trip_over) begin
            n_mode     = ST_EMERG;
            n_overload = 1'b1;
        end
        if ((n_mode != ST_OFF) && (n_mode != ST_EMERG) && run_over) begin
            n_mode    = ST_EMERG;
            n_timeout = 1'b1;
        end
        if (estop_ok) begin
            n_last_estop_ms = i_item.now_ms;
            n_mode          = ST_EMERG;
            n_overload      = 1'b0;
            n_timeout       = 1'b0;
        end
        if (start_ok) begin
            n_last_start_ms = i_item.now_ms;
            if ((n_mode == ST_OFF) || (n_mode == ST_EMERG)) begin
                n_overload      = 1'b0;
                n_timeout       = 1'b0;
                n_lamp          = 1'b0;
                n_mode          = ST_ACCEL;
                n_target        = go_down ? -mag : mag;
                n_next_dir_down = !go_down;
                n_run_start_ms  = i_item.now_ms;
            end else begin
                n_target = 9'sd0;
                n_mode   = ST_DECEL;
            end
        end

        unique case (n_mode)
            ST_ACCEL: begin
                if (step_due) begin
                    n_last_ramp_ms = i_item.now_ms;
                    if (n_speed < n_target) n_speed = n_speed + 9'sd1;
                    if (n_speed > n_target) n_speed = n_speed - 9'sd1;
                    if (n_speed == n_target) n_mode = ST_CRUISE;
                end
            end
            ST_CRUISE: begin
                if (cruise_due) begin
                    n_target = 9'sd0;
                    n_mode   = ST_DECEL;
                end
            end
            ST_DECEL: begin
                if (step_due) begin
                    n_last_ramp_ms = i_item.now_ms;
                    if (n_speed > 9'sd0) n_speed = n_speed - 9'sd1;
                    if (n_speed < 9'sd0) n_speed = n_speed + 9'sd1;
                    if (n_speed == 9'sd0) n_mode = ST_OFF;
                end
            end
            ST_EMERG: begin
                n_speed  = 9'sd0;
                n_target = 9'sd0;
                if (n_overload) begin
                    n_lamp = i_blink_on;
                end else if (n_timeout) begin
                    n_lamp = 1'b1;
                end else begin
                    n_lamp = 1'b0;
                end
            end
            ST_OFF: begin
            end
            default: begin
            end
        endcase
    end

    // Result of the pass, taken from the next state.
    assign neg_speed = -n_speed;

    always_comb begin
        o_result.mode           = mode_code(n_mode);
        o_result.speed          = n_speed;
        o_result.up_duty        = (n_speed > 9'sd0) ? n_speed[7:0] : 8'h00;
        o_result.down_duty      = (n_speed < 9'sd0) ? neg_speed[7:0] : 8'h00;
        o_result.fault_lamp     = n_lamp;
        o_result.overload_fault = n_overload;
        o_result.timeout_fault  = n_timeout;
    end

    // Controller state advances once per pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= ST_OFF;
            r_speed         <= 9'sd0;
            r_target        <= 9'sd0;
            r_next_dir_down <= 1'b0;
            r_last_ramp_ms  <= 32'h0;
            r_run_start_ms  <= 32'h0;
            r_last_start_ms <= 32'h0;
            r_last_estop_ms <= 32'h0;
            r_overload      <= 1'b0;
            r_timeout       <= 1'b0;
            r_lamp          <= 1'b0;
        end else if (i_step) begin
            r_mode          <= n_mode;
            r_speed         <= n_speed;
            r_target        <= n_target;
            r_next_dir_down <= n_next_dir_down;
            r_last_ramp_ms  <= n_last_ramp_ms;
            r_run_start_ms  <= n_run_start_ms;
            r_last_start_ms <= n_last_start_ms;
            r_last_estop_ms <= n_last_estop_ms;
            r_overload      <= n_overload;
            r_timeout       <= n_timeout;
            r_lamp          <= n_lamp;
        end
    end

endmodule

/* src/motor_ramp_safety_controller.sv */
// Motor ramp safety controller.
// Input stream: one transaction per control pass carrying the millisecond time, the
// start and emergency press events, both limit-switch levels and the filtered current.
// Output stream: exactly one transaction per pass with the mode, signed speed, forward
// and reverse duties, the fault lamp and the two fault flags.
// Configuration: write port with a register index. The user must write registers while
// the block is idle, as it does not enforce this; writes take effect on the next pass.
// Pipeline: an accepted transaction is registered in stages one, two and three, then in
// the result register. The first two stages reduce the time stamp modulo the 600 ms
// blink period (one multiply by a reciprocal, then a subtract and correct); the third
// stage runs the control pass. Throughput: one transaction per cycle while the receiver
// does not stall. Each stage has its own valid bit and moves on whenever the stage after
// it is empty or moving, so bubbles close up under a stall. When the receiver stalls, the
// result register holds and the stages behind it fill before s_axis_tready drops.
// Reset clears the mode to off, the speed, target, timestamps, fault flags and lamp,
// empties the pipeline and restores the configuration defaults.
module motor_ramp_safety_controller #(
    parameter int DUTY_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input transaction.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // now_ms[31:0], start_press[32], estop_press[33], upper_limit_hit[34],
    // lower_limit_hit[35], current_level[47:36]
    input  logic [47:0] s_axis_tdata,
    // Result transaction.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mode[2:0], speed[11:3], up_duty[19:12], down_duty[27:20], fault_lamp[28],
    // overload_fault[29], timeout_fault[30], zero[31]
    output logic [31:0] m_axis_tdata,
    // Configuration write port.
    input  logic                         i_cfg_we,
    input  logic [mrsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                  i_cfg_data
);
    import mrsc_pkg::*;

    // Largest run duty the drive accepts.
    localparam logic [7:0] DutyCap = (DUTY_BITS >= 8) ? 8'hFF : 8'((1 << DUTY_BITS) - 1);

    t_cfg    r_cfg;
    t_item   in_item;
    t_item   r_s1_item;
    t_item   r_s2_item;
    t_item   r_s3_item;
    logic    r_s1_valid;
    logic    r_s2_valid;
    logic    r_s3_valid;
    logic    r_out_valid;
    t_result r_out;
    t_result pass_result;
    logic    blink_on;
    logic    out_ready;
    logic    s3_ready;
    logic    s2_ready;
    logic    s1_ready;
    logic    s3_move;
    logic    s2_move;
    logic    s1_move;
    logic [7:0] duty_capped;

    // Configuration registers; the run duty is capped to the drive range on write.
    assign duty_capped = (i_cfg_data[7:0] > DutyCap) ? DutyCap : i_cfg_data[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_trip_level <= RST_TRIP_LEVEL;
            r_cfg.max_run_ms         <= RST_MAX_RUN;
            r_cfg.ramp_step_ms       <= RST_RAMP_STEP;
            r_cfg.cruise_ms          <= RST_CRUISE;
            r_cfg.debounce_ms        <= RST_DEBOUNCE;
            r_cfg.run_duty           <= (RST_RUN_DUTY > DutyCap) ? DutyCap : RST_RUN_DUTY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRIP_LEVEL: r_cfg.current_trip_level <= i_cfg_data[11:0];
                CFG_MAX_RUN:    r_cfg.max_run_ms         <= i_cfg_data;
                CFG_RAMP_STEP:  r_cfg.ramp_step_ms       <= i_cfg_data[15:0];
                CFG_CRUISE:     r_cfg.cruise_ms          <= i_cfg_data[15:0];
                CFG_DEBOUNCE:   r_cfg.debounce_ms        <= i_cfg_data[15:0];
                CFG_RUN_DUTY:   r_cfg.run_duty           <= duty_capped;
                default: begin
                end
            endcase
        end
    end

    // Unpack the input transaction.
    assign in_item.now_ms          = s_axis_tdata[31:0];
    assign in_item.start_press     = s_axis_tdata[32];
    assign in_item.estop_press     = s_axis_tdata[33];
    assign in_item.upper_limit_hit = s_axis_tdata[34];
    assign in_item.lower_limit_hit = s_axis_tdata[35];
    assign in_item.current_level   = s_axis_tdata[47:36];

    // Per-stage flow control.
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign s3_ready      = !r_s3_valid || out_ready;
    assign s2_ready      = !r_s2_valid || s3_ready;
    assign s1_ready      = !r_s1_valid || s2_ready;
    assign s3_move       = r_s3_valid && out_ready;
    assign s2_move       = r_s2_valid && s3_ready;
    assign s1_move       = r_s1_valid && s2_ready;
    assign s_axis_tready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready)  r_s1_valid  <= s_axis_tvalid;
            if (s2_ready)  r_s2_valid  <= r_s1_valid;
            if (s3_ready)  r_s3_valid  <= r_s2_valid;
            if (out_ready) r_out_valid <= r_s3_valid;
        end
    end

    // Item payload follows its valid bit down the pipeline.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s1_ready) r_s1_item <= in_item;
        if (s1_move)                   r_s2_item <= r_s1_item;
        if (s2_move)                   r_s3_item <= r_s2_item;
        if (s3_move)                   r_out     <= pass_result;
    end

    // Blink phase of the time stamp, computed alongside stages two and three.
    mrsc_blink u_blink (
        .i_clk        (i_clk),
        .i_load_quot  (s1_move),
        .i_load_phase (s2_move),
        .i_now_ms     (r_s1_item.now_ms),
        .o_blink_on   (blink_on)
    );

    // Control pass on the item in stage three.
    mrsc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (s3_move),
        .i_item     (r_s3_item),
        .i_blink_on (blink_on),
        .i_cfg      (r_cfg),
        .o_result   (pass_result)
    );

    // Pack the result transaction.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.timeout_fault, r_out.overload_fault, r_out.fault_lamp,
                            r_out.down_duty, r_out.up_duty, r_out.speed, r_out.mode};

endmodule

/* src/mrsc_checker.sv */
module mrsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [47:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        i_cfg_we,
    input logic [2:0]  i_cfg_idx,
    input logic [31:0] i_cfg_data
);
    import mrsc_pkg::*;

    logic [2:0] mode;
    logic [8:0] speed;
    logic [7:0] up_duty;
    logic [7:0] down_duty;
    logic       overload_fault;
    logic       timeout_fault;

    assign mode           = m_axis_tdata[2:0];
    assign speed          = m_axis_tdata[11:3];
    assign up_duty        = m_axis_tdata[19:12];
    assign down_duty      = m_axis_tdata[27:20];
    assign overload_fault = m_axis_tdata[29];
    assign timeout_fault  = m_axis_tdata[30];

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result stays put.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Forward and reverse drive are never on together.
    a_duty_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (up_duty == 8'h00) || (down_duty == 8'h00))
        else $error("both duties active");

    // Off and emergency always report a stopped motor.
    a_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ((mode == MODE_OFF) || (mode == MODE_EMERG)) |-> speed == 9'h000)
        else $error("motor moving while off or in emergency");

    // An overload trip and a timeout trip never stand together.
    a_one_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(overload_fault && timeout_fault))
        else $error("overload and timeout flags both set");

endmodule

bind motor_ramp_safety_controller mrsc_checker u_mrsc_checker (.*);
